// File: rtl/bsev_pkg.sv
// Shared codes and types for the B-spline evaluator.
package bsev_pkg;

  typedef logic [1:0] op_t;
  typedef logic [2:0] stat_t;
  typedef logic [1:0] mode_t;
  typedef logic [1:0] cfg_idx_t;

  // operation codes
  localparam op_t OP_LOAD_KNOT = 2'd0;
  localparam op_t OP_LOAD_COEF = 2'd1;
  localparam op_t OP_EVAL      = 2'd2;

  // result status codes
  localparam stat_t STAT_OK        = 3'd0;
  localparam stat_t STAT_RANGE     = 3'd1;
  localparam stat_t STAT_ORDER     = 3'd2;
  localparam stat_t STAT_FEW_KNOTS = 3'd3;
  localparam stat_t STAT_SAT       = 3'd4;

  // extrapolation modes (any other code rejects out-of-range arguments)
  localparam mode_t MODE_WRAP  = 2'd1;
  localparam mode_t MODE_CLAMP = 2'd2;

  // configuration register indexes
  localparam cfg_idx_t CFG_DEGREE = 2'd0;
  localparam cfg_idx_t CFG_KNOTS  = 2'd1;
  localparam cfg_idx_t CFG_EXTRAP = 2'd2;

  localparam int CFG_DW = 7;

endpackage

// File: rtl/bsev_ram.sv
// Generic simple dual-port RAM with registered read.
module bsev_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/bspline_eval_nonuniform.sv
// Non-uniform B-spline evaluator top level (sequencer, shared divider and multiplier).
//
// Each transaction is taken when start is high and busy is low, and gives exactly one
// result, shown on out_result_value/out_status for one cycle with out_valid high; the
// receiver cannot hold it off. Knot and coefficient loads answer in the next cycle and
// the block stays ready. An evaluate transaction keeps busy high while it runs: a setup
// that reads the domain-end knots and applies the extrapolation mode, a scan of the K
// knots for the span, a fetch of the d+1 local coefficients, then one step per
// derivative or de Boor term (d(d+1)/2 steps in all for degree d). A wrap-mode evaluate
// also divides the argument offset by the knot period. The step time is set by the one
// shared restoring divider, which retires one quotient bit per cycle; the multiplier is
// shared too and sits in a registered stage of its own. Config writes are taken any time
// but must only be issued while busy is low and no transaction is in flight.
module bspline_eval_nonuniform #(
  parameter int MAX_KNOTS  = 64,
  parameter int MAX_DEGREE = 5,
  parameter int FRAC_BITS  = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  // input transaction
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_op,
  input  logic [5:0]          in_table_index,
  input  logic signed [31:0]  in_load_value,
  input  logic signed [31:0]  in_x_arg,
  input  logic [1:0]          in_deriv_order,
  // result transaction
  output logic                out_valid,
  output logic signed [31:0]  out_result_value,
  output logic [2:0]          out_status,
  // configuration
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [bsev_pkg::CFG_DW-1:0] cfg_wdata
);

  localparam int AW  = $clog2(MAX_KNOTS);
  localparam int KW  = $clog2(MAX_KNOTS + 1);
  localparam int CW  = (KW > 7) ? KW : 7;          // knot count / index arithmetic
  localparam int DW  = $clog2(MAX_DEGREE + 1);     // local coefficient index
  localparam int NBW = 36 + FRAC_BITS;             // scaled divider dividend

  typedef enum logic [4:0] {
    S_IDLE, S_RLO, S_RHI, S_EXT, S_WRAPW, S_WRAPF, S_SPAN, S_SPANE,
    S_CA, S_CB, S_KA, S_KB, S_KC, S_KD, S_KE, S_DIVW, S_DPOST, S_MUL, S_UPD, S_FIN
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [2:0]  deg_r, deg_nxt;
  logic [6:0]  kcnt_r, kcnt_nxt;
  logic [1:0]  mode_r, mode_nxt;

  // evaluation datapath
  logic signed [31:0] x_r, x_nxt;
  logic [1:0]         ord_r, ord_nxt;
  logic signed [31:0] lo_r, lo_nxt;
  logic signed [31:0] kb_r, kb_nxt;
  logic signed [32:0] den_r, den_nxt;
  logic signed [32:0] diff_r, diff_nxt;
  logic signed [32:0] num_r, num_nxt;
  logic signed [64:0] prod_r, prod_nxt;
  logic signed [31:0] alpha_r, alpha_nxt;
  logic signed [31:0] t1_r, t1_nxt;
  logic signed [31:0] t0_r, t0_nxt;
  logic signed [31:0] a_r [MAX_DEGREE+1];
  logic signed [31:0] a_nxt [MAX_DEGREE+1];
  logic [CW-1:0]      i_r, i_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               pend_r, pend_nxt;
  logic [CW-1:0]      l_r, l_nxt;
  logic [2:0]         j_r, j_nxt;
  logic [2:0]         p_r, p_nxt;
  logic [2:0]         r_r, r_nxt;
  logic [2:0]         s_r, s_nxt;
  logic               ph_r, ph_nxt;    // 0 differentiate, 1 de Boor
  logic               sat_r, sat_nxt;

  // shared divider
  logic [31:0] dv_rem_r, dv_rem_nxt;
  logic [32:0] dv_sh_r, dv_sh_nxt;
  logic [32:0] dv_q_r, dv_q_nxt;
  logic [31:0] dv_d_r, dv_d_nxt;
  logic [5:0]  dv_cnt_r, dv_cnt_nxt;
  logic        dv_neg_r, dv_neg_nxt;
  logic        dv_big_r, dv_big_nxt;
  logic        dv_dz_r, dv_dz_nxt;

  // outputs
  logic               out_valid_r, out_valid_nxt;
  logic signed [31:0] out_res_r, out_res_nxt;
  logic [2:0]         out_stat_r, out_stat_nxt;

  // memories
  logic               knot_we, coef_we;
  logic [AW-1:0]      wr_addr;
  logic [AW-1:0]      knot_raddr, coef_raddr;
  logic [31:0]        knot_rdata, coef_rdata;
  logic               idx_ok;

  // combinational helpers
  logic [2:0]         de;
  logic [CW-1:0]      ke, de_c;
  logic               accept;
  logic [DW-1:0]      a_idx;
  logic signed [31:0] a_rd;
  logic signed [31:0] knot_q;
  logic               le;
  logic [CW-1:0]      base_i, hi_i, total;
  logic signed [32:0] per, wn;
  logic [32:0]        wn_mag;
  logic [32:0]        wm;
  logic [33:0]        trial;
  logic signed [36:0] nm;
  logic [36:0]        nm_mag;
  logic [NBW-1:0]     dvn;
  logic [32:0]        den_mag;
  logic [31:0]        q_mag;
  logic signed [31:0] qv;
  logic               qs;
  logic signed [31:0] mul_a;
  logic signed [64:0] mul_p;
  logic signed [64:0] shifted;
  logic signed [65:0] upd_sum;
  logic signed [31:0] upd_v;
  logic               upd_s;
  logic               diff_last, boor_last;

  bsev_ram #(.WIDTH(32), .DEPTH(MAX_KNOTS)) u_knot_ram (
    .clk   (clk),
    .we    (knot_we),
    .waddr (wr_addr),
    .wdata (in_load_value),
    .raddr (knot_raddr),
    .rdata (knot_rdata)
  );

  bsev_ram #(.WIDTH(32), .DEPTH(MAX_KNOTS)) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (wr_addr),
    .wdata (in_load_value),
    .raddr (coef_raddr),
    .rdata (coef_rdata)
  );

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_result_value = out_res_r;
  assign out_status       = out_stat_r;

  assign accept  = start && (state_r == S_IDLE);
  assign idx_ok  = (int'(in_table_index) < MAX_KNOTS);
  assign wr_addr = AW'(in_table_index);
  assign knot_we = accept && (in_op == bsev_pkg::OP_LOAD_KNOT) && idx_ok;
  assign coef_we = accept && (in_op == bsev_pkg::OP_LOAD_COEF) && idx_ok;

  // effective degree and knot count
  always_comb begin
    if (deg_r == 3'd0) begin
      de = 3'd1;
    end else if (int'(deg_r) > MAX_DEGREE) begin
      de = 3'(MAX_DEGREE);
    end else begin
      de = deg_r;
    end
    if (int'(kcnt_r) > MAX_KNOTS) begin
      ke = CW'(MAX_KNOTS);
    end else begin
      ke = CW'(kcnt_r);
    end
  end
  assign de_c = CW'(de);

  // knot indexes of the current step
  assign base_i = l_r - de_c + CW'(j_r);
  assign hi_i   = ph_r ? (base_i + CW'(p_r) + CW'(1) - CW'(r_r)) : (base_i + CW'(p_r));

  always_comb begin
    case (state_r)
      S_RLO:   knot_raddr = AW'(de_c);
      S_RHI:   knot_raddr = AW'(ke - de_c - CW'(1));
      S_SPAN:  knot_raddr = AW'(i_r);
      S_KA:    knot_raddr = AW'(hi_i);
      S_KB:    knot_raddr = AW'(base_i);
      default: knot_raddr = '0;
    endcase
  end
  assign coef_raddr = AW'(base_i);

  // single read port into the local coefficients
  always_comb begin
    case (state_r)
      S_KB:    a_idx = DW'(j_r - 3'd1);
      S_FIN:   a_idx = DW'(de);
      default: a_idx = DW'(j_r);
    endcase
  end
  assign a_rd   = a_r[a_idx];
  assign knot_q = knot_rdata;
  assign le     = (knot_q <= x_r);

  // wrap
  assign per    = 33'(knot_q) - 33'(lo_r);
  assign wn     = 33'(x_r) - 33'(lo_r);
  assign wn_mag = wn[32] ? 33'(-wn) : 33'(wn);
  assign wm     = (dv_neg_r && (dv_rem_r != 32'd0)) ? ({1'b0, dv_d_r} - {1'b0, dv_rem_r})
                                                    : {1'b0, dv_rem_r};

  // divider step and setup
  assign trial   = {1'b0, dv_rem_r, dv_sh_r[32]} - {2'b00, dv_d_r};
  assign nm      = ph_r ? 37'(num_r) : prod_r[36:0];
  assign nm_mag  = nm[36] ? 37'(-nm) : 37'(nm);
  assign dvn     = {nm_mag[35:0], {FRAC_BITS{1'b0}}};
  assign den_mag = den_r[32] ? 33'(-den_r) : 33'(den_r);

  // quotient sign and saturation
  assign q_mag = dv_q_r[31:0];
  always_comb begin
    qs = 1'b0;
    qv = $signed(q_mag);
    if (dv_dz_r) begin
      qv = '0;
    end else if (dv_big_r) begin
      qs = 1'b1;
      qv = dv_neg_r ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else if (dv_neg_r) begin
      if (q_mag > 32'h8000_0000) begin
        qs = 1'b1;
        qv = 32'sh8000_0000;
      end else begin
        qv = $signed(32'(32'd0 - q_mag));
      end
    end else if (q_mag[31]) begin
      qs = 1'b1;
      qv = 32'sh7fff_ffff;
    end
  end

  // shared multiplier
  assign mul_a = ph_r ? alpha_r : $signed({29'd0, p_r});
  assign mul_p = mul_a * diff_r;

  // interpolation update
  assign shifted = prod_r >>> FRAC_BITS;
  assign upd_sum = 66'(t0_r) + 66'(shifted);
  always_comb begin
    upd_s = 1'b0;
    upd_v = upd_sum[31:0];
    if (upd_sum > 66'sd2147483647) begin
      upd_s = 1'b1;
      upd_v = 32'sh7fff_ffff;
    end else if (upd_sum < -66'sd2147483648) begin
      upd_s = 1'b1;
      upd_v = 32'sh8000_0000;
    end
  end

  assign diff_last = (j_r == de - p_r + 3'd1);
  assign boor_last = (j_r == de - p_r + r_r);
  assign total     = cnt_r + (le ? CW'(1) : CW'(0));

  always_comb begin
    state_nxt     = state_r;
    deg_nxt       = deg_r;
    kcnt_nxt      = kcnt_r;
    mode_nxt      = mode_r;
    x_nxt         = x_r;
    ord_nxt       = ord_r;
    lo_nxt        = lo_r;
    kb_nxt        = kb_r;
    den_nxt       = den_r;
    diff_nxt      = diff_r;
    num_nxt       = num_r;
    prod_nxt      = prod_r;
    alpha_nxt     = alpha_r;
    t1_nxt        = t1_r;
    t0_nxt        = t0_r;
    a_nxt         = a_r;
    i_nxt         = i_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = pend_r;
    l_nxt         = l_r;
    j_nxt         = j_r;
    p_nxt         = p_r;
    r_nxt         = r_r;
    s_nxt         = s_r;
    ph_nxt        = ph_r;
    sat_nxt       = sat_r;
    dv_rem_nxt    = dv_rem_r;
    dv_sh_nxt     = dv_sh_r;
    dv_q_nxt      = dv_q_r;
    dv_d_nxt      = dv_d_r;
    dv_cnt_nxt    = dv_cnt_r;
    dv_neg_nxt    = dv_neg_r;
    dv_big_nxt    = dv_big_r;
    dv_dz_nxt     = dv_dz_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    out_stat_nxt  = out_stat_r;

    if (cfg_we) begin
      case (cfg_index)
        bsev_pkg::CFG_DEGREE: deg_nxt  = cfg_wdata[2:0];
        bsev_pkg::CFG_KNOTS:  kcnt_nxt = cfg_wdata[6:0];
        bsev_pkg::CFG_EXTRAP: mode_nxt = cfg_wdata[1:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_res_nxt  = '0;
          out_stat_nxt = bsev_pkg::STAT_OK;
          x_nxt        = in_x_arg;
          ord_nxt      = in_deriv_order;
          if (in_op == bsev_pkg::OP_EVAL) begin
            if (ke < {de_c[CW-2:0], 1'b0} + CW'(2)) begin
              out_valid_nxt = 1'b1;
              out_stat_nxt  = bsev_pkg::STAT_FEW_KNOTS;
            end else if ({1'b0, in_deriv_order} > de) begin
              out_valid_nxt = 1'b1;
              out_stat_nxt  = bsev_pkg::STAT_ORDER;
            end else begin
              state_nxt = S_RLO;
            end
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      S_RLO: state_nxt = S_RHI;
      S_RHI: begin
        lo_nxt    = knot_q;
        state_nxt = S_EXT;
      end
      S_EXT: begin
        // knot_q holds the upper end here
        i_nxt     = '0;
        cnt_nxt   = '0;
        pend_nxt  = 1'b0;
        state_nxt = S_SPAN;
        if (mode_r == bsev_pkg::MODE_WRAP) begin
          if (per <= 33'sd0) begin
            x_nxt = lo_r;
          end else begin
            dv_rem_nxt = '0;
            dv_sh_nxt  = wn_mag;
            dv_q_nxt   = '0;
            dv_d_nxt   = per[31:0];
            dv_cnt_nxt = 6'd33;
            dv_neg_nxt = wn[32];
            state_nxt  = S_WRAPW;
          end
        end else if (mode_r == bsev_pkg::MODE_CLAMP) begin
          if (x_r > knot_q) begin
            x_nxt = knot_q;
          end
          if (x_r < lo_r || (x_r > knot_q && knot_q < lo_r)) begin
            x_nxt = lo_r;
          end
        end else if (x_r < lo_r || x_r > knot_q) begin
          out_valid_nxt = 1'b1;
          out_stat_nxt  = bsev_pkg::STAT_RANGE;
          state_nxt     = S_IDLE;
        end
      end
      S_WRAPW, S_DIVW: begin
        if (dv_cnt_r != 6'd0) begin
          dv_cnt_nxt = dv_cnt_r - 6'd1;
          dv_sh_nxt  = {dv_sh_r[31:0], 1'b0};
          dv_q_nxt   = {dv_q_r[31:0], ~trial[33]};
          if (!trial[33]) begin
            dv_rem_nxt = trial[31:0];
          end else begin
            dv_rem_nxt = {dv_rem_r[30:0], dv_sh_r[32]};
          end
        end else begin
          state_nxt = (state_r == S_WRAPW) ? S_WRAPF : S_DPOST;
        end
      end
      S_WRAPF: begin
        x_nxt     = 32'(34'(lo_r) + 34'({1'b0, wm}));
        state_nxt = S_SPAN;
      end
      S_SPAN: begin
        pend_nxt = 1'b1;
        if (pend_r && le) begin
          cnt_nxt = cnt_r + CW'(1);
        end
        if (i_r == ke - CW'(1)) begin
          state_nxt = S_SPANE;
        end else begin
          i_nxt = i_r + CW'(1);
        end
      end
      S_SPANE: begin
        if (total > ke - de_c - CW'(1)) begin
          l_nxt = ke - de_c - CW'(2);
        end else if (total < de_c + CW'(1)) begin
          l_nxt = de_c;
        end else begin
          l_nxt = total - CW'(1);
        end
        j_nxt     = '0;
        sat_nxt   = 1'b0;
        state_nxt = S_CA;
      end
      S_CA: state_nxt = S_CB;
      S_CB: begin
        a_nxt[DW'(j_r)] = coef_rdata;
        if (j_r == de) begin
          p_nxt     = de;
          s_nxt     = '0;
          r_nxt     = 3'd1;
          ph_nxt    = (ord_r == 2'd0);
          state_nxt = S_KA;
        end else begin
          j_nxt     = j_r + 3'd1;
          state_nxt = S_CA;
        end
      end
      S_KA: begin
        t1_nxt    = a_rd;
        state_nxt = S_KB;
      end
      S_KB: begin
        kb_nxt    = knot_q;
        t0_nxt    = a_rd;
        state_nxt = S_KC;
      end
      S_KC: begin
        den_nxt   = 33'(kb_r) - 33'(knot_q);
        diff_nxt  = 33'(t1_r) - 33'(t0_r);
        num_nxt   = 33'(x_r) - 33'(knot_q);
        state_nxt = S_KD;
      end
      S_KD: begin
        prod_nxt  = mul_p;   // p times difference, used when differentiating
        state_nxt = S_KE;
      end
      S_KE: begin
        dv_dz_nxt  = (den_r == 33'sd0);
        dv_neg_nxt = nm[36] ^ den_r[32];
        dv_big_nxt = (64'(dvn >> 32) >= 64'(den_mag));
        dv_d_nxt   = den_mag[31:0];
        dv_rem_nxt = 32'(dvn >> 32);
        dv_sh_nxt  = {dvn[31:0], 1'b0};
        dv_q_nxt   = '0;
        dv_cnt_nxt = ((den_r == 33'sd0) || (64'(dvn >> 32) >= 64'(den_mag))) ? 6'd0 : 6'd32;
        state_nxt  = S_DIVW;
      end
      S_DPOST: begin
        sat_nxt = sat_r | qs;
        if (ph_r) begin
          alpha_nxt = qv;
          state_nxt = S_MUL;
        end else begin
          a_nxt[DW'(j_r)] = qv;
          state_nxt       = S_KA;
          if (diff_last) begin
            p_nxt = p_r - 3'd1;
            j_nxt = de;
            if (s_r + 3'd1 == {1'b0, ord_r}) begin
              ph_nxt = 1'b1;
              r_nxt  = 3'd1;
              if (p_r == 3'd1) begin
                state_nxt = S_FIN;
              end
            end else begin
              s_nxt = s_r + 3'd1;
            end
          end else begin
            j_nxt = j_r - 3'd1;
          end
        end
      end
      S_MUL: begin
        prod_nxt  = mul_p;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        a_nxt[DW'(j_r)] = upd_v;
        sat_nxt         = sat_r | upd_s;
        state_nxt       = S_KA;
        if (boor_last) begin
          if (r_r == p_r) begin
            state_nxt = S_FIN;
          end else begin
            r_nxt = r_r + 3'd1;
            j_nxt = de;
          end
        end else begin
          j_nxt = j_r - 3'd1;
        end
      end
      S_FIN: begin
        out_valid_nxt = 1'b1;
        out_res_nxt   = a_rd;
        out_stat_nxt  = sat_r ? bsev_pkg::STAT_SAT : bsev_pkg::STAT_OK;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    ord_r      <= ord_nxt;
    lo_r       <= lo_nxt;
    kb_r       <= kb_nxt;
    den_r      <= den_nxt;
    diff_r     <= diff_nxt;
    num_r      <= num_nxt;
    prod_r     <= prod_nxt;
    alpha_r    <= alpha_nxt;
    t1_r       <= t1_nxt;
    t0_r       <= t0_nxt;
    a_r        <= a_nxt;
    i_r        <= i_nxt;
    cnt_r      <= cnt_nxt;
    l_r        <= l_nxt;
    j_r        <= j_nxt;
    p_r        <= p_nxt;
    r_r        <= r_nxt;
    s_r        <= s_nxt;
    ph_r       <= ph_nxt;
    sat_r      <= sat_nxt;
    dv_rem_r   <= dv_rem_nxt;
    dv_sh_r    <= dv_sh_nxt;
    dv_q_r     <= dv_q_nxt;
    dv_d_r     <= dv_d_nxt;
    dv_neg_r   <= dv_neg_nxt;
    dv_big_r   <= dv_big_nxt;
    dv_dz_r    <= dv_dz_nxt;
    out_res_r  <= out_res_nxt;
    out_stat_r <= out_stat_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      deg_r       <= 3'd3;
      kcnt_r      <= 7'd8;
      mode_r      <= 2'd0;
      pend_r      <= 1'b0;
      dv_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      deg_r       <= deg_nxt;
      kcnt_r      <= kcnt_nxt;
      mode_r      <= mode_nxt;
      pend_r      <= pend_nxt;
      dv_cnt_r    <= dv_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: rtl/bsev_chk.sv
// Port-level checker for the B-spline evaluator, with its bind.
module bsev_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [31:0] out_result_value,
  input logic [2:0]  out_status
);

  // a result is only shown once the sequencer is back to ready
  a_res_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // an accepted transaction either answers at once or starts work
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid || busy))
    else $error("accepted transaction dropped");

  // finishing an evaluation always delivers its result
  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("evaluation ended without result");

  // error results carry a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != bsev_pkg::STAT_OK && out_status != bsev_pkg::STAT_SAT)
      |-> (out_result_value == 32'd0))
    else $error("error result with nonzero value");

endmodule

bind bspline_eval_nonuniform bsev_chk u_bsev_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_result_value (out_result_value),
  .out_status       (out_status)
);
